// ----- rtl/core/bppc_pkg.sv -----
// ----------------------------------------------------------------------------
// bppc_pkg
// Shared types and constants for the button packet press classifier.
// ----------------------------------------------------------------------------
package bppc_pkg;

	localparam logic [7:0]  FRAME_START      = 8'h53;
	localparam logic [7:0]  FRAME_KIND       = 8'h05;
	localparam logic [2:0]  FRAME_LEN        = 3'd4;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd300;
	localparam int unsigned QUEUE_DEPTH      = 2;

	// key codes of a result
	localparam logic [1:0] KEY_ENTER  = 2'd0;
	localparam logic [1:0] KEY_ESCAPE = 2'd1;
	localparam logic [1:0] KEY_DOWN   = 2'd2;
	localparam logic [1:0] KEY_UP     = 2'd3;

	// event handed from the framer to the button logic
	typedef struct packed {
		logic        is_tick;
		logic [15:0] bitmap;
	} bppc_evt_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} bppc_q_stat_t;

endpackage

// ----- rtl/core/bppc_in_if.sv -----
// ----------------------------------------------------------------------------
// bppc_in_if
// Input channel: received byte or millisecond tick.
// ----------------------------------------------------------------------------
interface bppc_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ----- rtl/core/bppc_out_if.sv -----
// ----------------------------------------------------------------------------
// bppc_out_if
// Output channel: classified key code.
// ----------------------------------------------------------------------------
interface bppc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink   (input valid, input key_code, output ready);
endinterface

// ----- rtl/core/bppc_front.sv -----
// ----------------------------------------------------------------------------
// bppc_front
// Frame assembler: collects bytes into 4-byte frames, checks the header and
// forwards ticks and valid button frames as events.
// ----------------------------------------------------------------------------
module bppc_front (
	input  logic             clk,
	input  logic             arst_n,
	bppc_in_if.sink          item,
	input  logic             evt_ready,
	output logic             evt_push,
	output bppc_pkg::bppc_evt_t evt
);
	import bppc_pkg::*;

	logic [7:0] frame_bytes_q [3];
	logic [2:0] frame_count_q;
	logic       accept;
	logic       restart;
	logic [2:0] cnt_base;
	logic [2:0] cnt_next;
	logic       frame_ok;

	assign item.ready = evt_ready;
	assign accept     = item.valid & item.ready;

	always_comb begin
		restart  = (item.rx_byte == FRAME_START) || (frame_count_q >= FRAME_LEN);
		cnt_base = restart ? 3'd0 : frame_count_q;
		cnt_next = cnt_base + 3'd1;
		// bytes 0..2 are already stored when the fourth arrives
		frame_ok = (cnt_next == FRAME_LEN) &&
			(frame_bytes_q[0] == FRAME_START) && (frame_bytes_q[1] == FRAME_KIND);
		evt_push    = accept & (item.cmd | frame_ok);
		evt.is_tick = item.cmd;
		evt.bitmap  = {frame_bytes_q[2], item.rx_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q    <= 3'd0;
			frame_bytes_q[0] <= 8'd0;
			frame_bytes_q[1] <= 8'd0;
			frame_bytes_q[2] <= 8'd0;
		end else if (accept && !item.cmd) begin
			frame_count_q <= cnt_next;
			if (cnt_base < 3'd3) begin
				frame_bytes_q[cnt_base[1:0]] <= item.rx_byte;
			end
		end
	end

endmodule

// ----- rtl/core/bppc_queue.sv -----
// ----------------------------------------------------------------------------
// bppc_queue
// Small event FIFO between the frame assembler and the button logic.
// ----------------------------------------------------------------------------
module bppc_queue #(
	parameter int unsigned DEPTH = bppc_pkg::QUEUE_DEPTH // 2 or more
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bppc_pkg::bppc_evt_t    wr_data,
	input  logic                   pop,
	output bppc_pkg::bppc_evt_t    rd_data,
	output bppc_pkg::bppc_q_stat_t stat
);
	import bppc_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bppc_evt_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/bppc_back.sv -----
// ----------------------------------------------------------------------------
// bppc_back
// Button logic: keeps the bitmap, millisecond count and press times,
// classifies releases and holds the result in an output register.
// ----------------------------------------------------------------------------
module bppc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	input  bppc_pkg::bppc_evt_t    evt,
	input  bppc_pkg::bppc_q_stat_t q_stat,
	output logic                   pop,
	bppc_out_if.source             result
);
	import bppc_pkg::*;

	logic [15:0] long_press_q;
	logic [15:0] button_bits_q;
	logic [31:0] ms_clock_q;
	logic [31:0] press_time_q [2];
	logic        out_valid_q;
	logic [1:0]  key_code_q;

	logic        take;
	logic        is_frame;
	logic [31:0] held0;
	logic [31:0] held1;
	logic        long0;
	logic        long1;
	logic [1:0]  rel;
	logic [1:0]  press;
	logic        have;
	logic [1:0]  code;

	assign take            = !out_valid_q || result.ready;
	assign pop             = !q_stat.empty && take;
	assign result.valid    = out_valid_q;
	assign result.key_code = key_code_q;

	always_comb begin
		is_frame = pop && !evt.is_tick;
		held0    = ms_clock_q - press_time_q[0];
		held1    = ms_clock_q - press_time_q[1];
		long0    = held0 >= {16'd0, long_press_q};
		long1    = held1 >= {16'd0, long_press_q};
		rel      = button_bits_q[1:0] & ~evt.bitmap[1:0];
		press    = ~button_bits_q[1:0] & evt.bitmap[1:0];
		have     = is_frame && (rel != 2'b00);
		// button 1 wins when both are released together
		if (rel[1]) begin
			code = long1 ? KEY_UP : KEY_DOWN;
		end else begin
			code = long0 ? KEY_ESCAPE : KEY_ENTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			long_press_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_bits_q   <= '0;
			ms_clock_q      <= '0;
			press_time_q[0] <= '0;
			press_time_q[1] <= '0;
		end else if (pop) begin
			if (evt.is_tick) begin
				ms_clock_q <= ms_clock_q + 32'd1;
			end else begin
				button_bits_q <= evt.bitmap;
				if (press[0]) begin
					press_time_q[0] <= ms_clock_q;
				end
				if (press[1]) begin
					press_time_q[1] <= ms_clock_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (have) begin
			key_code_q <= code;
		end
	end

endmodule

// ----- rtl/core/button_packet_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_packet_press_classifier
// Turns button bitmap frames from a serial link into key codes.
// ----------------------------------------------------------------------------
// item:   one transaction is a received byte (cmd 0) or a millisecond tick
//         (cmd 1). Bytes build 4-byte frames; 0x53 resyncs the frame.
// result: one transaction per frame that releases button 0 or 1: enter/escape for
//         button 0, down/up for button 1, long when held >= long_press_ms.
// cfg_we/cfg_wdata: write long_press_ms, only while the block is idle.
// Throughput: one item per cycle while the queue has room; the button logic
// retires one queued event per cycle unless result is stalled.
// The event of the last frame byte is written into the queue when the byte
// is accepted; when the button logic retires it, it loads the output
// register and result.valid rises.
// If result.ready is low the output register holds; the queue keeps taking
// items until it fills (QDEPTH events), then item.ready drops.
// Reset clears the frame, bitmap, tick count and press times and sets
// long_press_ms to 300.
// ----------------------------------------------------------------------------
module button_packet_press_classifier #(
	parameter int unsigned QDEPTH = bppc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	bppc_in_if.sink     item,
	bppc_out_if.source  result,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import bppc_pkg::*;

	bppc_evt_t    evt_in;
	bppc_evt_t    evt_out;
	logic         q_push;
	logic         q_pop;
	bppc_q_stat_t q_stat;

	bppc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.evt_ready (!q_stat.full),
		.evt_push  (q_push),
		.evt       (evt_in)
	);

	bppc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (evt_in),
		.pop     (q_pop),
		.rd_data (evt_out),
		.stat    (q_stat)
	);

	bppc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_out),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.result    (result)
	);

	a_push_not_full : assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("event pushed into full queue");

	a_stat_exclusive : assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	a_tick_queued : assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.cmd) |=> !q_stat.empty)
		else $error("accepted tick not queued");

	a_result_from_pop : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(q_pop))
		else $error("result without a retired event");

endmodule
